// ===== src/pam_pkg.sv =====
// Shared types and constants of the position automaton word matcher.
`timescale 1ns / 1ps

package pam_pkg;

    localparam int POSITIONS = 64;
    localparam int CNT_W     = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;

    localparam int POS_W  = 6;
    localparam int ROW_W  = 64;
    localparam int SYM_W  = 8;
    localparam int WORD_W = 32;
    localparam int DATA_W = 64;
    localparam int ADDR_W = 5;

    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_SYMBOL = 2'd1;
    localparam logic [1:0] MODE_EMPTY  = 2'd2;

    localparam logic [1:0] REG_INITIAL_MASK = 2'd0;
    localparam logic [1:0] REG_FINAL_MASK   = 2'd1;
    localparam logic [1:0] REG_ACCEPT_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]       mode;
        logic [POS_W-1:0] position;
        logic [ROW_W-1:0] follow_row;
        logic [SYM_W-1:0] position_symbol;
        logic [SYM_W-1:0] symbol;
        logic             last;
    } t_in_item;

    typedef struct packed {
        logic              matched;
        logic [WORD_W-1:0] word_number;
    } t_out_item;

    typedef struct packed {
        logic [POSITIONS-1:0] row;
        logic [SYM_W-1:0]     sym;
    } t_load;

endpackage

// ===== src/pam_cell.sv =====
// One position cell: stored follow row and symbol, symbol compare, follow union stage.
`timescale 1ns / 1ps

module pam_cell (
    input  logic                            i_clk,
    input  logic                            i_wr_en,
    input  pam_pkg::t_load                  i_load,
    input  logic [pam_pkg::SYM_W-1:0]       i_sym,
    input  logic                            i_active,
    input  logic [pam_pkg::POSITIONS-1:0]   i_acc,
    output logic [pam_pkg::POSITIONS-1:0]   o_acc,
    output logic                            o_hit
);

    logic [pam_pkg::POSITIONS-1:0] r_row;
    logic [pam_pkg::SYM_W-1:0]     r_sym;
    logic [pam_pkg::POSITIONS-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_row <= i_load.row;
            r_sym <= i_load.sym;
        end
        r_acc <= i_acc | (i_active ? r_row : '0);
    end

    assign o_acc = r_acc;
    assign o_hit = (r_sym == i_sym);

endmodule

// ===== src/pam_chain.sv =====
// Row of position cells; the follow union ripples one cell per cycle.
`timescale 1ns / 1ps

module pam_chain (
    input  logic                            i_clk,
    input  logic [pam_pkg::POSITIONS-1:0]   i_wr_en,
    input  pam_pkg::t_load                  i_load,
    input  logic [pam_pkg::SYM_W-1:0]       i_sym,
    input  logic [pam_pkg::POSITIONS-1:0]   i_active,
    output logic [pam_pkg::POSITIONS-1:0]   o_union,
    output logic [pam_pkg::POSITIONS-1:0]   o_hits
);

    logic [pam_pkg::POSITIONS-1:0] w_acc [0:pam_pkg::POSITIONS];

    assign w_acc[0] = '0;

    for (genvar p = 0; p < pam_pkg::POSITIONS; p++) begin : g_cell
        pam_cell u_cell (
            .i_clk    (i_clk),
            .i_wr_en  (i_wr_en[p]),
            .i_load   (i_load),
            .i_sym    (i_sym),
            .i_active (i_active[p]),
            .i_acc    (w_acc[p]),
            .o_acc    (w_acc[p+1]),
            .o_hit    (o_hits[p])
        );
    end

    assign o_union = w_acc[pam_pkg::POSITIONS];

endmodule

// ===== src/position_automaton_word_matcher_core.sv =====
// Top level of the position automaton word matcher: control, registers and cell chain.
//
// Input beats carry a mode: load one position's symbol and follow row, feed one
// symbol of the current word, or report the empty word. Result beats carry the
// match flag and the 32-bit wrapping word number, one per finished word.
// The user writes the automaton's initial set, final set and empty-word flag
// over the APB port only while the block is idle; the block itself does not
// enforce this. pready is always high. One beat is worked on at a time;
// o_in_stall is high while it is in progress. A load is written as it is taken.
// The first symbol of a word goes straight to the step state; every later one
// first sweeps the follow union through the chain of position cells, one cell
// per cycle, before the symbol mask is applied. An ending symbol or empty word
// then posts its result to the output register, visible in the next cycle.
// While a result waits under i_out_stall, further beats are taken; a second
// result waits inside the block until the output register frees up.
// Synchronous reset clears the active set, the word state, the word counter,
// the output valid flag and the configuration registers. Stored positions are
// undefined until loaded.
`timescale 1ns / 1ps

module position_automaton_word_matcher_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  pam_pkg::t_in_item               i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output pam_pkg::t_out_item              o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pam_pkg::ADDR_W-1:0]      paddr,
    input  logic [pam_pkg::DATA_W-1:0]      pwdata,
    output logic [pam_pkg::DATA_W-1:0]      prdata,
    output logic                            pready
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_STEP,
        S_POST
    } t_state;

    t_state                          r_state;
    logic [pam_pkg::CNT_W-1:0]       r_cnt;
    logic                            r_inside;
    logic [pam_pkg::POSITIONS-1:0]   r_active;
    logic [pam_pkg::SYM_W-1:0]       r_sym;
    logic                            r_last;
    logic                            r_match;
    logic [pam_pkg::WORD_W-1:0]      r_word_cnt;
    logic                            r_out_valid;
    pam_pkg::t_out_item              r_out;
    logic [pam_pkg::DATA_W-1:0]      r_initial_mask;
    logic [pam_pkg::DATA_W-1:0]      r_final_mask;
    logic                            r_accept_empty;

    logic                            w_in_acc;
    logic                            w_cfg_wr;
    logic [1:0]                      w_reg_idx;
    logic [pam_pkg::POSITIONS-1:0]   w_wr_en;
    pam_pkg::t_load                  w_load;
    logic [pam_pkg::POSITIONS-1:0]   w_union;
    logic [pam_pkg::POSITIONS-1:0]   w_hits;
    logic [pam_pkg::POSITIONS-1:0]   n_active;
    logic                            w_post_ok;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_post_ok  = !r_out_valid || !i_out_stall;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = paddr[pam_pkg::ADDR_W-1:3];

    always_comb begin
        case (w_reg_idx)
            pam_pkg::REG_INITIAL_MASK: prdata = r_initial_mask;
            pam_pkg::REG_FINAL_MASK:   prdata = r_final_mask;
            pam_pkg::REG_ACCEPT_EMPTY: prdata = {{(pam_pkg::DATA_W-1){1'b0}}, r_accept_empty};
            default:                   prdata = '0;
        endcase
    end

    assign w_load.row = i_in.follow_row[pam_pkg::POSITIONS-1:0];
    assign w_load.sym = i_in.position_symbol;

    for (genvar p = 0; p < pam_pkg::POSITIONS; p++) begin : g_wr
        assign w_wr_en[p] = w_in_acc && (i_in.mode == pam_pkg::MODE_LOAD)
                            && (i_in.position == pam_pkg::POS_W'(p));
    end

    pam_chain u_chain (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_load   (w_load),
        .i_sym    (r_sym),
        .i_active (r_active),
        .o_union  (w_union),
        .o_hits   (w_hits)
    );

    assign n_active = (r_inside ? w_union : r_initial_mask[pam_pkg::POSITIONS-1:0]) & w_hits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_cnt          <= '0;
            r_inside       <= 1'b0;
            r_active       <= '0;
            r_word_cnt     <= '0;
            r_out_valid    <= 1'b0;
            r_initial_mask <= '0;
            r_final_mask   <= '0;
            r_accept_empty <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                case (w_reg_idx)
                    pam_pkg::REG_INITIAL_MASK: r_initial_mask <= pwdata;
                    pam_pkg::REG_FINAL_MASK:   r_final_mask   <= pwdata;
                    pam_pkg::REG_ACCEPT_EMPTY: r_accept_empty <= pwdata[0];
                    default: ;
                endcase
            end

            if (r_state == S_POST && w_post_ok) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        case (i_in.mode)
                            pam_pkg::MODE_SYMBOL: begin
                                r_sym  <= i_in.symbol;
                                r_last <= i_in.last;
                                r_cnt  <= '0;
                                r_state <= r_inside ? S_SWEEP : S_STEP;
                            end
                            pam_pkg::MODE_EMPTY: begin
                                r_match <= r_accept_empty;
                                r_state <= S_POST;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SWEEP: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == pam_pkg::CNT_W'(pam_pkg::POSITIONS - 1)) begin
                        r_state <= S_STEP;
                    end
                end
                S_STEP: begin
                    r_active <= n_active;
                    r_match  <= |(n_active & r_final_mask[pam_pkg::POSITIONS-1:0]);
                    if (r_last) begin
                        r_state <= S_POST;
                    end else begin
                        r_inside <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_POST: begin
                    if (w_post_ok) begin
                        r_out.matched     <= r_match;
                        r_out.word_number <= r_word_cnt;
                        r_word_cnt        <= r_word_cnt + 1'b1;
                        r_inside          <= 1'b0;
                        r_active          <= '0;
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_sweep_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP || r_state == S_STEP) |-> o_in_stall)
        else $error("input taken during a step");

    a_out_from_post: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_POST))
        else $error("result beat not posted by the post state");

    a_count_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POST && w_post_ok) |=> (r_word_cnt == $past(r_word_cnt) + 1'b1))
        else $error("word counter did not advance on a posted result");

    a_idle_outside_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !r_inside) |-> (r_active == '0))
        else $error("active set left over between words");

endmodule
